// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every rising edge, off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/r2q_pkg.sv =====
package r2q_pkg;

  // element and result width
  localparam int DATA_W        = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int OUT_MAG_MAX   = 32767;

  // Shepperd branch: which component carries the radicand
  typedef enum logic [3:0] {
    BR_W = 4'b0001,
    BR_X = 4'b0010,
    BR_Y = 4'b0100,
    BR_Z = 4'b1000
  } br_t;

endpackage

// ===== hw/rtl/r2q_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module r2q_isqrt
  import r2q_pkg::*;
#(
  parameter int N_W  = 38,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [N_W-1:0]    in_n,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_v,
  output logic [N_W/2-1:0]  out_s,
  output logic [SB_W-1:0]   out_sb
);

  localparam int S_W   = N_W / 2;
  localparam int REM_W = S_W + 3;

  logic                v_r   [S_W];
  logic [N_W-1:0]      n_r   [S_W];
  logic [REM_W-1:0]    rem_r [S_W];
  logic [S_W-1:0]      q_r   [S_W];
  logic [SB_W-1:0]     sb_r  [S_W];

  for (genvar k = 0; k < S_W; k++) begin : g_stage
    logic             v_i;
    logic [N_W-1:0]   n_i;
    logic [REM_W-1:0] rem_i;
    logic [S_W-1:0]   q_i;
    logic [SB_W-1:0]  sb_i;
    logic [REM_W-1:0] rsh;
    logic [REM_W-1:0] trial;
    logic             ge;
    logic [REM_W-1:0] rem_nxt;
    logic [S_W-1:0]   q_nxt;

    if (k == 0) begin : g_first
      assign v_i   = in_v;
      assign n_i   = in_n;
      assign rem_i = '0;
      assign q_i   = '0;
      assign sb_i  = in_sb;
    end else begin : g_next
      assign v_i   = v_r[k-1];
      assign n_i   = n_r[k-1];
      assign rem_i = rem_r[k-1];
      assign q_i   = q_r[k-1];
      assign sb_i  = sb_r[k-1];
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
      rsh     = {rem_i[REM_W-3:0], n_i[N_W-1:N_W-2]};
      trial   = REM_W'({q_i, 2'b01});
      ge      = (rsh >= trial);
      rem_nxt = ge ? (rsh - trial) : rsh;
      q_nxt   = {q_i[S_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]   <= n_i << 2;
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        sb_r[k]  <= sb_i;
      end
    end
  end

  assign out_v  = v_r[S_W-1];
  assign out_s  = q_r[S_W-1];
  assign out_sb = sb_r[S_W-1];

endmodule

// ===== hw/rtl/r2q_div.sv =====
// Pipelined rounded divide: (m * 2^FRAC_BITS + s/2) / s, one quotient bit per stage.
// Requires m <= s, so the quotient fits FRAC_BITS+1 bits.
module r2q_div
  import r2q_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAG_W     = 18,
  parameter int SB_W      = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic [MAG_W-1:0]     in_m,
  input  logic [MAG_W:0]       in_s,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_v,
  output logic [FRAC_BITS:0]   out_q,
  output logic [SB_W-1:0]      out_sb
);

  localparam int Q_W = FRAC_BITS + 1;
  localparam int S_W = MAG_W + 1;
  localparam int D_W = MAG_W + FRAC_BITS + 1;

  logic [D_W-1:0] dvd;

  logic            v_r   [Q_W];
  logic [S_W-1:0]  s_r   [Q_W];
  logic [S_W-1:0]  rem_r [Q_W];
  logic [Q_W-1:0]  lo_r  [Q_W];
  logic [Q_W-1:0]  q_r   [Q_W];
  logic [SB_W-1:0] sb_r  [Q_W];

  // dividend with the rounding half-divisor folded in
  assign dvd = D_W'({in_m, {FRAC_BITS{1'b0}}}) + D_W'(in_s[S_W-1:1]);

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic            v_i;
    logic [S_W-1:0]  s_i;
    logic [S_W-1:0]  rem_i;
    logic [Q_W-1:0]  lo_i;
    logic [Q_W-1:0]  q_i;
    logic [SB_W-1:0] sb_i;
    logic [S_W:0]    rsh;
    logic            ge;
    logic [S_W:0]    diff;
    logic [S_W-1:0]  rem_nxt;

    if (k == 0) begin : g_first
      assign v_i   = in_v;
      assign s_i   = in_s;
      assign rem_i = {1'b0, dvd[D_W-1:Q_W]};
      assign lo_i  = dvd[Q_W-1:0];
      assign q_i   = '0;
      assign sb_i  = in_sb;
    end else begin : g_next
      assign v_i   = v_r[k-1];
      assign s_i   = s_r[k-1];
      assign rem_i = rem_r[k-1];
      assign lo_i  = lo_r[k-1];
      assign q_i   = q_r[k-1];
      assign sb_i  = sb_r[k-1];
    end

    // restoring step
    always_comb begin
      rsh     = {rem_i, lo_i[Q_W-1]};
      ge      = (rsh >= {1'b0, s_i});
      diff    = rsh - {1'b0, s_i};
      rem_nxt = ge ? diff[S_W-1:0] : rsh[S_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k]   <= s_i;
        rem_r[k] <= rem_nxt;
        lo_r[k]  <= lo_i << 1;
        q_r[k]   <= {q_i[Q_W-2:0], ge};
        sb_r[k]  <= sb_i;
      end
    end
  end

  assign out_v  = v_r[Q_W-1];
  assign out_q  = q_r[Q_W-1];
  assign out_sb = sb_r[Q_W-1];

endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Pipeline from request accept to result: 5 front stages, one square-root stage per
//   root bit, one divider stage per quotient bit, clamp stage, output register.
// Throughput: one request per cycle while the skid slot is empty; in_ready drops
//   while it is full. A two-entry output register/skid pair keeps the pipeline moving
//   while one result waits.
// Reset: synchronous active-low rst_n clears all valid bits; data regs are not reset.
module rotation_matrix_to_quaternion
  import r2q_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_r00,
  input  logic signed [DATA_W-1:0] in_r01,
  input  logic signed [DATA_W-1:0] in_r02,
  input  logic signed [DATA_W-1:0] in_r10,
  input  logic signed [DATA_W-1:0] in_r11,
  input  logic signed [DATA_W-1:0] in_r12,
  input  logic signed [DATA_W-1:0] in_r20,
  input  logic signed [DATA_W-1:0] in_r21,
  input  logic signed [DATA_W-1:0] in_r22,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_quat_w,
  output logic signed [DATA_W-1:0] out_quat_x,
  output logic signed [DATA_W-1:0] out_quat_y,
  output logic signed [DATA_W-1:0] out_quat_z,
  output logic                     out_degenerate
);

  `include "assert_macros.svh"

  localparam int EXT_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int MAG_W = EXT_W - 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int N_W   = SQ_W + 2;
  localparam int S_W   = N_W / 2;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int ISB_W = 4 * MAG_W + 5;

  typedef logic signed [EXT_W-1:0] ext_t;

  localparam ext_t ONE_FX = ext_t'(1) <<< FRAC_BITS;

  logic en;
  logic skid_v_r;

  // ---------------- stage 0: input register
  logic                     s0_v_r;
  logic signed [DATA_W-1:0] m00_r, m01_r, m02_r, m10_r, m11_r, m12_r, m20_r, m21_r, m22_r;

  assign en       = ~skid_v_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m00_r <= in_r00; m01_r <= in_r01; m02_r <= in_r02;
      m10_r <= in_r10; m11_r <= in_r11; m12_r <= in_r12;
      m20_r <= in_r20; m21_r <= in_r21; m22_r <= in_r22;
    end
  end

  // ---------------- stage 1: trace, branch, radicand, off-diagonal sums and differences
  ext_t e00, e01, e02, e10, e11, e12, e20, e21, e22, trace;
  br_t  br_nxt;
  ext_t rad_nxt;

  logic s1_v_r;
  br_t  br_r;
  ext_t rad_r, dx_r, dy_r, dz_r, sxy_r, sxz_r, syz_r;

  always_comb begin
    e00 = ext_t'(m00_r); e01 = ext_t'(m01_r); e02 = ext_t'(m02_r);
    e10 = ext_t'(m10_r); e11 = ext_t'(m11_r); e12 = ext_t'(m12_r);
    e20 = ext_t'(m20_r); e21 = ext_t'(m21_r); e22 = ext_t'(m22_r);
    trace = e00 + e11 + e22;
    // ties fall to the later branch
    if (trace > 0) begin
      br_nxt = BR_W;
    end else if ((e00 > e11) && (e00 > e22)) begin
      br_nxt = BR_X;
    end else if (e11 > e22) begin
      br_nxt = BR_Y;
    end else begin
      br_nxt = BR_Z;
    end
    unique case (br_nxt)
      BR_W:    rad_nxt = trace + ONE_FX;
      BR_X:    rad_nxt = ONE_FX + e00 - e11 - e22;
      BR_Y:    rad_nxt = ONE_FX + e11 - e00 - e22;
      BR_Z:    rad_nxt = ONE_FX + e22 - e00 - e11;
      default: rad_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      br_r  <= br_nxt;
      rad_r <= rad_nxt;
      dx_r  <= e21 - e12;
      dy_r  <= e02 - e20;
      dz_r  <= e10 - e01;
      sxy_r <= e01 + e10;
      sxz_r <= e02 + e20;
      syz_r <= e12 + e21;
    end
  end

  // ---------------- stage 2: place components, magnitude and sign
  ext_t                   vc [4];
  logic                   deg_nxt;
  logic [3:0][MAG_W-1:0]  mag_nxt;
  logic [3:0]             sgn_nxt;

  logic                   s2_v_r;
  logic                   s2_deg_r;
  logic [3:0][MAG_W-1:0]  s2_mag_r;
  logic [3:0]             s2_sgn_r;

  always_comb begin
    unique case (br_r)
      BR_W: begin
        vc[0] = rad_r; vc[1] = dx_r;  vc[2] = dy_r;  vc[3] = dz_r;
      end
      BR_X: begin
        vc[0] = dx_r;  vc[1] = rad_r; vc[2] = sxy_r; vc[3] = sxz_r;
      end
      BR_Y: begin
        vc[0] = dy_r;  vc[1] = sxy_r; vc[2] = rad_r; vc[3] = syz_r;
      end
      BR_Z: begin
        vc[0] = dz_r;  vc[1] = sxz_r; vc[2] = syz_r; vc[3] = rad_r;
      end
      default: begin
        vc[0] = '0; vc[1] = '0; vc[2] = '0; vc[3] = '0;
      end
    endcase
    deg_nxt = (rad_r <= 0);
    // degenerate items run through as an all-zero vector
    for (int i = 0; i < 4; i++) begin
      ext_t absv;
      absv       = (vc[i] < 0) ? -vc[i] : vc[i];
      mag_nxt[i] = deg_nxt ? '0 : absv[MAG_W-1:0];
      sgn_nxt[i] = ~deg_nxt & (vc[i] < 0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_deg_r <= deg_nxt;
      s2_mag_r <= mag_nxt;
      s2_sgn_r <= sgn_nxt;
    end
  end

  // ---------------- stage 3: squares
  logic                   s3_v_r;
  logic                   s3_deg_r;
  logic [3:0][MAG_W-1:0]  s3_mag_r;
  logic [3:0]             s3_sgn_r;
  logic [3:0][SQ_W-1:0]   sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_deg_r <= s2_deg_r;
      s3_mag_r <= s2_mag_r;
      s3_sgn_r <= s2_sgn_r;
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= SQ_W'(s2_mag_r[i]) * SQ_W'(s2_mag_r[i]);
      end
    end
  end

  // ---------------- stage 4: squared norm
  logic                   s4_v_r;
  logic [ISB_W-1:0]       s4_sb_r;
  logic [N_W-1:0]         norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sb_r <= {s3_deg_r, s3_sgn_r, s3_mag_r};
      norm_r  <= (N_W'(sq_r[0]) + N_W'(sq_r[1])) + (N_W'(sq_r[2]) + N_W'(sq_r[3]));
    end
  end

  // ---------------- square root
  logic                   sq_v;
  logic [S_W-1:0]         sq_s;
  logic [ISB_W-1:0]       sq_sb;
  logic [S_W-1:0]         s_fix;
  logic                   rt_deg;
  logic [3:0]             rt_sgn;
  logic [3:0][MAG_W-1:0]  rt_mag;

  r2q_isqrt #(
    .N_W  (N_W),
    .SB_W (ISB_W)
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (s4_v_r),
    .in_n   (norm_r),
    .in_sb  (s4_sb_r),
    .out_v  (sq_v),
    .out_s  (sq_s),
    .out_sb (sq_sb)
  );

  assign {rt_deg, rt_sgn, rt_mag} = sq_sb;
  // a zero norm divides by one
  assign s_fix = (sq_s == '0) ? S_W'(1) : sq_s;

  // ---------------- four dividers
  logic [3:0]             dv_v;
  logic [3:0][Q_W-1:0]    dv_q;
  logic [3:0]             dv_sgn;
  logic                   dv_deg;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    if (i == 0) begin : g_deg
      r2q_div #(
        .FRAC_BITS (FRAC_BITS),
        .MAG_W     (MAG_W),
        .SB_W      (2)
      ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (sq_v),
        .in_m   (rt_mag[i]),
        .in_s   (s_fix),
        .in_sb  ({rt_deg, rt_sgn[i]}),
        .out_v  (dv_v[i]),
        .out_q  (dv_q[i]),
        .out_sb ({dv_deg, dv_sgn[i]})
      );
    end else begin : g_plain
      r2q_div #(
        .FRAC_BITS (FRAC_BITS),
        .MAG_W     (MAG_W),
        .SB_W      (1)
      ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (sq_v),
        .in_m   (rt_mag[i]),
        .in_s   (s_fix),
        .in_sb  (rt_sgn[i]),
        .out_v  (dv_v[i]),
        .out_q  (dv_q[i]),
        .out_sb (dv_sgn[i])
      );
    end
  end

  // ---------------- clamp and restore sign
  logic [3:0][DATA_W-1:0] fin_nxt;
  logic                   fin_v_r;
  logic                   fin_deg_r;
  logic [3:0][DATA_W-1:0] fin_q_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [31:0]       qx;
      logic [DATA_W-1:0] qm;
      qx         = 32'(dv_q[i]);
      qm         = (qx > 32'(OUT_MAG_MAX)) ? DATA_W'(OUT_MAG_MAX) : qx[DATA_W-1:0];
      fin_nxt[i] = dv_sgn[i] ? (~qm + DATA_W'(1)) : qm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= &dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_deg_r <= dv_deg;
      fin_q_r   <= fin_nxt;
    end
  end

  // ---------------- output register with skid slot
  logic                   push;
  logic                   take;
  logic                   out_v_r;
  logic                   out_deg_r, skid_deg_r;
  logic [3:0][DATA_W-1:0] out_q_r, skid_q_r;

  assign push = en & fin_v_r;
  assign take = out_ready | ~out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      out_v_r  <= skid_v_r | push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_q_r   <= skid_v_r ? skid_q_r : fin_q_r;
      out_deg_r <= skid_v_r ? skid_deg_r : fin_deg_r;
    end else if (push) begin
      skid_q_r   <= fin_q_r;
      skid_deg_r <= fin_deg_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_quat_w     = out_q_r[0];
  assign out_quat_x     = out_q_r[1];
  assign out_quat_y     = out_q_r[2];
  assign out_quat_z     = out_q_r[3];
  assign out_degenerate = out_deg_r;

  // ---------------- checks
  `ASSERT_CLK(a_deg_zero, !(out_v_r && out_deg_r) || (out_q_r == '0), "degenerate result not zero")
  `ASSERT_CLK(a_skid_order, !skid_v_r || out_v_r, "skid slot full with empty output register")
  `ASSERT_NEXT(a_skid_hold, skid_v_r && !out_ready, skid_v_r && $stable(skid_q_r), "skid entry lost")

endmodule

// ===== tb/sv/rotation_matrix_to_quaternion_tb.sv =====
module rotation_matrix_to_quaternion_tb
  import r2q_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FRAC;
  localparam int LATENCY = 50;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef struct {
    elem_t r [9];
  } matrix_t;
  typedef struct {
    elem_t w, x, y, z;
    logic degen;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  elem_t in_r [9];
  logic out_valid;
  logic out_ready = 1'b0;
  elem_t out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic out_degenerate;

  matrix_t pending_q [$];
  quat_t expected_q [$];
  int mismatches = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  always #1 clk = ~clk;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_r00(in_r[0]), .in_r01(in_r[1]), .in_r02(in_r[2]),
    .in_r10(in_r[3]), .in_r11(in_r[4]), .in_r12(in_r[5]),
    .in_r20(in_r[6]), .in_r21(in_r[7]), .in_r22(in_r[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z),
    .out_degenerate(out_degenerate)
  );

  initial for (int i = 0; i < 9; i++) in_r[i] = '0;

  // bitwise integer square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // round half away from zero, clamp magnitude
  function automatic elem_t normalize_component(longint v, longint unsigned s);
    longint unsigned m, q;
    m = (v < 0) ? longint'(-v) : longint'(v);
    q = (m * longint'(ONE) + s / 2) / s;
    if (q > OUT_MAG_MAX) q = OUT_MAG_MAX;
    return (v < 0) ? elem_t'(-longint'(q)) : elem_t'(q);
  endfunction

  // Shepperd conversion of one matrix
  function automatic quat_t shepperd_quat(matrix_t m);
    longint a [9];
    longint v [4];
    longint tr, rad;
    longint unsigned n, s;
    quat_t q;
    for (int i = 0; i < 9; i++) a[i] = longint'(m.r[i]);
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      rad = tr + ONE;
      v[0] = rad; v[1] = a[7] - a[5]; v[2] = a[2] - a[6]; v[3] = a[3] - a[1];
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      rad = ONE + a[0] - a[4] - a[8];
      v[0] = a[7] - a[5]; v[1] = rad; v[2] = a[1] + a[3]; v[3] = a[2] + a[6];
    end else if (a[4] > a[8]) begin
      rad = ONE + a[4] - a[0] - a[8];
      v[0] = a[2] - a[6]; v[1] = a[1] + a[3]; v[2] = rad; v[3] = a[5] + a[7];
    end else begin
      rad = ONE + a[8] - a[0] - a[4];
      v[0] = a[3] - a[1]; v[1] = a[2] + a[6]; v[2] = a[5] + a[7]; v[3] = rad;
    end
    if (rad <= 0) begin
      q.w = '0; q.x = '0; q.y = '0; q.z = '0; q.degen = 1'b1;
      return q;
    end
    n = 0;
    for (int i = 0; i < 4; i++) n += longint'(v[i] * v[i]);
    s = floor_sqrt(n);
    if (s == 0) s = 1;
    q.w = normalize_component(v[0], s);
    q.x = normalize_component(v[1], s);
    q.y = normalize_component(v[2], s);
    q.z = normalize_component(v[3], s);
    q.degen = 1'b0;
    return q;
  endfunction

  // matrix from an axis-angle, with small noise when noisy is set
  function automatic matrix_t rotation_matrix(bit noisy);
    real ax, ay, az, nrm, th, c, s, t;
    real f [9];
    matrix_t m;
    ax = real'($urandom_range(2000)) - 1000.0;
    ay = real'($urandom_range(2000)) - 1000.0;
    az = real'($urandom_range(2000)) - 1000.0;
    nrm = $sqrt(ax * ax + ay * ay + az * az);
    if (nrm == 0.0) begin
      ax = 1.0; nrm = 1.0;
    end
    ax /= nrm; ay /= nrm; az /= nrm;
    th = real'($urandom_range(62832)) / 10000.0;
    c = $cos(th); s = $sin(th); t = 1.0 - c;
    f[0] = t*ax*ax + c;    f[1] = t*ax*ay - s*az; f[2] = t*ax*az + s*ay;
    f[3] = t*ax*ay + s*az; f[4] = t*ay*ay + c;    f[5] = t*ay*az - s*ax;
    f[6] = t*ax*az - s*ay; f[7] = t*ay*az + s*ax; f[8] = t*az*az + c;
    for (int i = 0; i < 9; i++) begin
      m.r[i] = elem_t'($rtoi(f[i] * real'(ONE)));
      if (noisy) m.r[i] += elem_t'($urandom_range(16) - 8);
    end
    return m;
  endfunction

  function automatic matrix_t diag_matrix(int d0, int d1, int d2, int off);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.r[i] = elem_t'(off);
    m.r[0] = elem_t'(d0); m.r[4] = elem_t'(d1); m.r[8] = elem_t'(d2);
    return m;
  endfunction

  // stimulus: directed corners then mostly rotations
  initial begin
    matrix_t m;
    int one_i;
    one_i = int'(ONE);
    pending_q.push_back(diag_matrix(one_i, one_i, one_i, 0));
    pending_q.push_back(diag_matrix(one_i, -one_i, -one_i, 0));
    pending_q.push_back(diag_matrix(-one_i, one_i, -one_i, 0));
    pending_q.push_back(diag_matrix(-one_i, -one_i, one_i, 0));
    pending_q.push_back(diag_matrix(0, 0, 0, 0));
    pending_q.push_back(diag_matrix(-one_i, -one_i, -one_i, 0));
    pending_q.push_back(diag_matrix(-32768, -32768, -32768, -32768));
    pending_q.push_back(diag_matrix(32767, 32767, 32767, 32767));
    pending_q.push_back(diag_matrix(32767, -32768, 32767, -32768));
    pending_q.push_back(diag_matrix(-100, -100, -100, 5));
    pending_q.push_back(diag_matrix(-100, -200, -200, 7));
    pending_q.push_back(diag_matrix(-200, -100, -100, 7));
    pending_q.push_back(diag_matrix(-300, -100, -300, 9));
    pending_q.push_back(diag_matrix(-32768, 32767, -32768, 1));
    pending_q.push_back(diag_matrix(32767, -32768, -32768, -1));
    pending_q.push_back(diag_matrix(1, -1, 0, 0));
    m = diag_matrix(0, 0, 0, 0);
    for (int i = 0; i < 9; i++) m.r[i] = (i % 2) ? elem_t'(16'h5555) : elem_t'(16'hAAAA);
    pending_q.push_back(m);
    for (int k = 0; k < 1650; k++) begin
      case ($urandom_range(9))
        0, 1: begin
          for (int i = 0; i < 9; i++) m.r[i] = elem_t'($urandom);
        end
        2: m = diag_matrix(-int'($urandom_range(20000)), -int'($urandom_range(20000)),
                           -int'($urandom_range(20000)), int'($urandom_range(200)) - 100);
        default: m = rotation_matrix($urandom_range(1));
      endcase
      pending_q.push_back(m);
    end
    stim_done = 1'b1;
  end

  // request driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_valid <= 1'b1;
          for (int i = 0; i < 9; i++) in_r[i] <= pending_q[0].r[i];
          pending_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(40, 1);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // predict at request accept
  always @(posedge clk) begin
    matrix_t acc;
    if (rst_n && in_valid && in_ready) begin
      for (int i = 0; i < 9; i++) acc.r[i] = in_r[i];
      expected_q.push_back(shepperd_quat(acc));
    end
  end

  // receiver stall pattern: periodic windows plus random stalls
  always @(posedge clk) begin
    if (rst_n) begin
      stall_phase <= (stall_phase + 1) % 300;
      if (stall_phase < 100) out_ready <= 1'b1;
      else if (stall_phase < 200) out_ready <= ($urandom_range(3) != 0);
      else out_ready <= ($urandom_range(2) == 0);
    end
  end

  // result monitor
  always @(posedge clk) begin
    quat_t exp_q;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        exp_q = expected_q.pop_front();
        if (out_quat_w !== exp_q.w || out_quat_x !== exp_q.x || out_quat_y !== exp_q.y ||
            out_quat_z !== exp_q.z || out_degenerate !== exp_q.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp w=%0d x=%0d y=%0d z=%0d d=%0b got w=%0d x=%0d y=%0d z=%0d d=%0b",
                     exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.degen,
                     out_quat_w, out_quat_x, out_quat_y, out_quat_z, out_degenerate);
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== rotation_matrix_to_quaternion.f =====
+incdir+hw/rtl
hw/rtl/r2q_pkg.sv
hw/rtl/r2q_isqrt.sv
hw/rtl/r2q_div.sv
hw/rtl/rotation_matrix_to_quaternion.sv
tb/sv/rotation_matrix_to_quaternion_tb.sv
